/* hdl/lfr_pkg.sv */
// package for the l2 flood replication filter
// beat structs, opcode codes and fixed field widths; no dependencies
package lfr_pkg;

  // fixed widths of the interface fields
  localparam int unsigned PORT_FIELD_W  = 16;
  localparam int unsigned GROUP_W       = 8;
  localparam int unsigned PACKET_W      = 16;
  localparam int unsigned DOMAIN_W      = 4;
  localparam int unsigned SLOT_W        = 5;
  localparam int unsigned COUNT_W       = 6;
  localparam int unsigned DOMAIN_SPACE  = 1 << DOMAIN_W;

  // input operations; code 3 is unused and does nothing
  typedef enum logic [1:0] {
    OP_WRITE_SLOT = 2'd0,
    OP_SET_COUNT  = 2'd1,
    OP_FLOOD      = 2'd2
  } op_e;

  // input beat
  typedef struct packed {
    op_e                       op;
    logic [DOMAIN_W-1:0]       domain;
    logic [SLOT_W-1:0]         slot;
    logic [PORT_FIELD_W-1:0]   member_port;
    logic [GROUP_W-1:0]        member_group;
    logic                      member_bvi;
    logic [COUNT_W-1:0]        count;
    logic [PORT_FIELD_W-1:0]   rx_port;
    logic [GROUP_W-1:0]        rx_group;
    logic [PACKET_W-1:0]       packet_id;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [PACKET_W-1:0]       out_packet;
    logic [PORT_FIELD_W-1:0]   tx_port;
    logic                      to_bvi;
    logic                      dropped;
    logic                      last;
  } out_beat_t;

  // packet context handed to the walker when a flood starts
  typedef struct packed {
    logic [PACKET_W-1:0]       packet_id;
    logic [PORT_FIELD_W-1:0]   rx_port;
    logic [GROUP_W-1:0]        rx_group;
  } flood_req_t;

endpackage

/* hdl/lfr_member_ram.sv */
// member table storage: one write port, one registered read port
// plain array, no reset; no package dependency
module lfr_member_ram #(
  parameter int unsigned ADDR_W = 9,
  parameter int unsigned DATA_W = 25
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/lfr_walker.sv */
// flood walker: steps the member slots down from the flood count,
// one compare unit filters each slot, holds one pending copy for the last flag; uses lfr_pkg
module lfr_walker #(
  parameter int unsigned NUM_DOMAINS = 16,
  parameter int unsigned MAX_MEMBERS = 32,
  parameter int unsigned PORT_WIDTH  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lfr_pkg::flood_req_t req_i,
  input  logic [((NUM_DOMAINS < lfr_pkg::DOMAIN_SPACE ? NUM_DOMAINS : lfr_pkg::DOMAIN_SPACE)
                 > 1 ? $clog2(NUM_DOMAINS < lfr_pkg::DOMAIN_SPACE ? NUM_DOMAINS
                 : lfr_pkg::DOMAIN_SPACE) : 1)-1:0] dom_i,
  input  logic [$clog2(MAX_MEMBERS+1)-1:0] cnt_i,
  output logic               busy_o,
  output logic               rd_en_o,
  output logic [((NUM_DOMAINS < lfr_pkg::DOMAIN_SPACE ? NUM_DOMAINS : lfr_pkg::DOMAIN_SPACE)
                 > 1 ? $clog2(NUM_DOMAINS < lfr_pkg::DOMAIN_SPACE ? NUM_DOMAINS
                 : lfr_pkg::DOMAIN_SPACE) : 1)
                + (MAX_MEMBERS > 1 ? $clog2(MAX_MEMBERS) : 1) - 1:0] rd_addr_o,
  input  logic [PORT_WIDTH+lfr_pkg::GROUP_W:0] rd_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lfr_pkg::out_beat_t out_o
);
  import lfr_pkg::*;

  localparam int unsigned DOM_N = (NUM_DOMAINS < DOMAIN_SPACE) ? NUM_DOMAINS : DOMAIN_SPACE;
  localparam int unsigned DW    = (DOM_N > 1) ? $clog2(DOM_N) : 1;
  localparam int unsigned SW    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int unsigned CW    = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned MW    = PORT_WIDTH + GROUP_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e                  state_q, state_d;
  logic [PACKET_W-1:0]     pkt_q, pkt_d;
  logic [PORT_WIDTH-1:0]   rxp_q, rxp_d;
  logic [GROUP_W-1:0]      rxg_q, rxg_d;
  logic [DW-1:0]           dom_q, dom_d;
  logic [CW-1:0]           left_q, left_d;
  logic [SW-1:0]           idx_q, idx_d;
  logic                    chk_q, chk_d;
  logic                    pend_q, pend_d;
  logic [PORT_WIDTH-1:0]   pend_port_q, pend_port_d;
  logic                    pend_bvi_q, pend_bvi_d;
  logic                    out_valid_q, out_valid_d;
  out_beat_t               out_q, out_d;

  logic [PORT_WIDTH-1:0]   m_port;
  logic [GROUP_W-1:0]      m_group;
  logic                    m_bvi;
  logic                    out_free;
  logic                    elig;
  logic                    blocked;
  logic [CW-1:0]           cnt_m1;

  // member word fields from the read port
  assign m_port  = rd_data_i[MW-1 -: PORT_WIDTH];
  assign m_group = rd_data_i[GROUP_W:1];
  assign m_bvi   = rd_data_i[0];

  // filter: skip the receive interface and the packet's own split-horizon group
  assign out_free = !out_valid_q || !out_stall_i;
  assign elig     = chk_q && (m_port != rxp_q) && ((rxg_q == '0) || (m_group != rxg_q));
  assign blocked  = elig && pend_q && !out_free;
  assign cnt_m1   = cnt_i - CW'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    pkt_d       = pkt_q;
    rxp_d       = rxp_q;
    rxg_d       = rxg_q;
    dom_d       = dom_q;
    left_d      = left_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    pend_port_d = pend_port_q;
    pend_bvi_d  = pend_bvi_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pkt_d   = req_i.packet_id;
          rxp_d   = PORT_WIDTH'(req_i.rx_port);
          rxg_d   = req_i.rx_group;
          dom_d   = dom_i;
          left_d  = cnt_i;
          idx_d   = cnt_m1[SW-1:0];
          chk_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!blocked) begin
          // issue the next slot read or finish the walk
          if (left_q != '0) begin
            rd_en_o = 1'b1;
            left_d  = left_q - CW'(1);
            idx_d   = idx_q - SW'(1);
            chk_d   = 1'b1;
          end else begin
            chk_d   = 1'b0;
            state_d = ST_FIN;
          end
          // an eligible member releases the pending copy as a non-final beat
          if (elig) begin
            if (pend_q) begin
              out_d.out_packet = pkt_q;
              out_d.tx_port    = PORT_FIELD_W'(pend_port_q);
              out_d.to_bvi     = 1'b0;
              out_d.dropped    = 1'b0;
              out_d.last       = 1'b0;
              out_valid_d      = 1'b1;
            end
            pend_d      = 1'b1;
            pend_port_d = m_port;
            pend_bvi_d  = m_bvi;
          end
        end
      end
      ST_FIN: begin
        // final beat: last copy with its bvi flag, or a drop
        if (out_free) begin
          out_d.out_packet = pkt_q;
          out_d.tx_port    = pend_q ? PORT_FIELD_W'(pend_port_q) : '0;
          out_d.to_bvi     = pend_q && pend_bvi_q;
          out_d.dropped    = !pend_q;
          out_d.last       = 1'b1;
          out_valid_d      = 1'b1;
          pend_d           = 1'b0;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pkt_q       <= '0;
      rxp_q       <= '0;
      rxg_q       <= '0;
      dom_q       <= '0;
      left_q      <= '0;
      idx_q       <= '0;
      chk_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_port_q <= '0;
      pend_bvi_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      pkt_q       <= pkt_d;
      rxp_q       <= rxp_d;
      rxg_q       <= rxg_d;
      dom_q       <= dom_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      chk_q       <= chk_d;
      pend_q      <= pend_d;
      pend_port_q <= pend_port_d;
      pend_bvi_q  <= pend_bvi_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign rd_addr_o   = {dom_q, idx_q};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hdl/l2_flood_replication_filter.sv */
// l2 flood replication filter, top level; uses lfr_pkg, lfr_member_ram, lfr_walker
// slot writes and count writes are registered; a flood with count n reads slots n-1 to 0
// and gives one copy per eligible member, or a single drop beat when none is eligible
// throughput: one flood at a time; one table slot per cycle unless stalled by the output
// reset: asynchronous, flood counts cleared to zero; member table contents undefined
module l2_flood_replication_filter #(
  parameter int unsigned NUM_DOMAINS = 16,
  parameter int unsigned MAX_MEMBERS = 32,
  parameter int unsigned PORT_WIDTH  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lfr_pkg::in_beat_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lfr_pkg::out_beat_t out_o
);
  import lfr_pkg::*;

  localparam int unsigned DOM_N  = (NUM_DOMAINS < DOMAIN_SPACE) ? NUM_DOMAINS : DOMAIN_SPACE;
  localparam int unsigned DW     = (DOM_N > 1) ? $clog2(DOM_N) : 1;
  localparam int unsigned SW     = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int unsigned CW     = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned MW     = PORT_WIDTH + GROUP_W + 1;
  localparam int unsigned AW     = DW + SW;
  localparam int unsigned CDEPTH = 1 << DW;

  logic              busy;
  logic              accept;
  logic              dom_ok;
  logic              slot_ok;
  logic [DW-1:0]     dom_idx;
  logic [SW-1:0]     slot_idx;
  logic [CW-1:0]     cnt_sat;
  logic [CW-1:0]     cnt_rd;
  logic              wr_en;
  logic [MW-1:0]     wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [MW-1:0]     rd_data;
  logic              start;
  flood_req_t        req;
  logic [CW-1:0]     counts_q [CDEPTH];

  // input beat decode
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign dom_ok     = 32'(in_i.domain) < NUM_DOMAINS;
  assign slot_ok    = 32'(in_i.slot) < MAX_MEMBERS;
  assign dom_idx    = DW'(in_i.domain);
  assign slot_idx   = SW'(in_i.slot);
  assign cnt_sat    = (32'(in_i.count) > MAX_MEMBERS) ? CW'(MAX_MEMBERS) : CW'(in_i.count);

  // flood count table, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CDEPTH; i++) begin
        counts_q[i] <= '0;
      end
    end else if (accept && (in_i.op == OP_SET_COUNT) && dom_ok) begin
      counts_q[dom_idx] <= cnt_sat;
    end
  end

  assign cnt_rd = dom_ok ? counts_q[dom_idx] : '0;

  // member slot writes
  assign wr_en   = accept && (in_i.op == OP_WRITE_SLOT) && dom_ok && slot_ok;
  assign wr_data = {PORT_WIDTH'(in_i.member_port), in_i.member_group, in_i.member_bvi};

  // flood start
  assign start         = accept && (in_i.op == OP_FLOOD);
  assign req.packet_id = in_i.packet_id;
  assign req.rx_port   = in_i.rx_port;
  assign req.rx_group  = in_i.rx_group;

  lfr_member_ram #(
    .ADDR_W (AW),
    .DATA_W (MW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i ({dom_idx, slot_idx}),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lfr_walker #(
    .NUM_DOMAINS (NUM_DOMAINS),
    .MAX_MEMBERS (MAX_MEMBERS),
    .PORT_WIDTH  (PORT_WIDTH)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .dom_i       (dom_idx),
    .cnt_i       (cnt_rd),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

/* tb/tb_l2_flood_replication_filter.sv */
// self-checking testbench for the l2 flood replication filter
// depends on lfr_pkg and l2_flood_replication_filter; a clocked driver and monitor
// feed beats and check each copy against a per-domain member table predictor
module tb_l2_flood_replication_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  localparam int NUM_DOMAINS = 16;
  localparam int MAX_MEMBERS = 32;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_BEATS = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_o;

  l2_flood_replication_filter #(
    .NUM_DOMAINS(NUM_DOMAINS),
    .MAX_MEMBERS(MAX_MEMBERS),
    .PORT_WIDTH (16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predicted bridge state
  logic [15:0] mbr_port [NUM_DOMAINS][MAX_MEMBERS];
  logic [7:0]  mbr_group[NUM_DOMAINS][MAX_MEMBERS];
  logic        mbr_bvi  [NUM_DOMAINS][MAX_MEMBERS];
  int          flood_cnt[NUM_DOMAINS];
  out_beat_t   copies_q[$];

  // stimulus bookkeeping
  in_beat_t    beats_q[$];
  int          pause_q[$];
  bit          slot_written[NUM_DOMAINS][MAX_MEMBERS];
  int          total_beats = 0;
  int          beats_sent = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          floods = 0;
  int          drops = 0;
  int          errors = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  out_beat_t   want;

  // flood replication with split-horizon filtering, one beat at a time
  function automatic void replicate(in_beat_t b);
    int picks[$];
    out_beat_t c;
    case (b.op)
      OP_WRITE_SLOT: begin
        mbr_port[b.domain][b.slot]  = b.member_port;
        mbr_group[b.domain][b.slot] = b.member_group;
        mbr_bvi[b.domain][b.slot]   = b.member_bvi;
      end
      OP_SET_COUNT: begin
        flood_cnt[b.domain] = (b.count > MAX_MEMBERS) ? MAX_MEMBERS : int'(b.count);
      end
      OP_FLOOD: begin
        floods++;
        // walk from the top slot down, skipping rx port and same nonzero group
        for (int i = flood_cnt[b.domain] - 1; i >= 0; i--) begin
          if (mbr_port[b.domain][i] != b.rx_port &&
              (b.rx_group == '0 || mbr_group[b.domain][i] != b.rx_group))
            picks.push_back(i);
        end
        if (picks.size() == 0) begin
          drops++;
          c.out_packet = b.packet_id;
          c.tx_port    = '0;
          c.to_bvi     = 1'b0;
          c.dropped    = 1'b1;
          c.last       = 1'b1;
          copies_q.push_back(c);
        end else begin
          foreach (picks[k]) begin
            c.out_packet = b.packet_id;
            c.tx_port    = mbr_port[b.domain][picks[k]];
            c.dropped    = 1'b0;
            c.last       = (k == picks.size() - 1);
            // only the final copy may take the bvi path
            c.to_bvi     = c.last ? mbr_bvi[b.domain][picks[k]] : 1'b0;
            copies_q.push_back(c);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // idling is on in stretches and off near the end
  function automatic bit idle_on();
    return (beats_sent < total_beats - 60) && ((beats_sent / 50) % 4 != 3);
  endfunction

  function automatic in_beat_t noise_beat();
    logic [95:0] r;
    in_beat_t b;
    r = {$urandom, $urandom, $urandom};
    b = r[$bits(in_beat_t)-1:0];
    return b;
  endfunction

  // small pools half the time so rx port and group hit members often
  function automatic logic [15:0] pick_port();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_group();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  // number of slots written contiguously from slot zero
  function automatic int prefix_len(int d);
    int n;
    n = 0;
    while (n < MAX_MEMBERS && slot_written[d][n]) n++;
    return n;
  endfunction

  task automatic add_write(int d, int s, logic [15:0] p, logic [7:0] g, logic v);
    in_beat_t b;
    b = noise_beat();
    b.op           = OP_WRITE_SLOT;
    b.domain       = d[3:0];
    b.slot         = s[4:0];
    b.member_port  = p;
    b.member_group = g;
    b.member_bvi   = v;
    slot_written[d][s] = 1'b1;
    beats_q.push_back(b);
  endtask

  task automatic add_count(int d, int c);
    in_beat_t b;
    b = noise_beat();
    b.op     = OP_SET_COUNT;
    b.domain = d[3:0];
    b.count  = c[5:0];
    beats_q.push_back(b);
  endtask

  task automatic add_flood(int d, logic [15:0] rxp, logic [7:0] rxg, logic [15:0] id);
    in_beat_t b;
    b = noise_beat();
    b.op        = OP_FLOOD;
    b.domain    = d[3:0];
    b.rx_port   = rxp;
    b.rx_group  = rxg;
    b.packet_id = id;
    beats_q.push_back(b);
  endtask

  // legal count: only slots already written may fall under it
  task automatic add_legal_count(int d);
    int pl;
    pl = prefix_len(d);
    add_count(d, (pl == MAX_MEMBERS) ? $urandom_range(0, 63) : $urandom_range(0, pl));
  endtask

  task automatic add_unused();
    in_beat_t b;
    b = noise_beat();
    b.op = op_e'(OP_UNUSED);
    beats_q.push_back(b);
  endtask

  task automatic build_stimulus();
    int d;
    int n;
    int base;
    bit first;
    bit mid_paused;
    // directed: empty domain, filtering rules, bvi on last copy, drops
    add_flood(0, 16'hFFFF, 8'hFF, 16'h0000);
    add_write(1, 0, 16'hFFFF, 8'hFF, 1'b1);
    add_write(1, 1, 16'h0000, 8'h00, 1'b0);
    add_write(1, 2, 16'h0005, 8'h03, 1'b1);
    add_count(1, 3);
    add_flood(1, 16'h0007, 8'h00, 16'hFFFF);
    add_flood(1, 16'h0005, 8'h00, 16'h1234);
    add_flood(1, 16'h0009, 8'h03, 16'h00FF);
    add_flood(1, 16'h0009, 8'hFF, 16'hFF00);
    add_flood(1, 16'h0000, 8'hFF, 16'h5A5A);
    add_flood(1, 16'hFFFF, 8'h03, 16'hA5A5);
    add_count(1, 2);
    add_flood(1, 16'h0000, 8'hFF, 16'h0001);
    add_unused();
    add_write(15, 31, 16'hFFFF, 8'hFF, 1'b1);
    add_write(15, 30, 16'h0000, 8'h00, 1'b0);
    add_count(1, 0);
    add_flood(1, 16'h1111, 8'h00, 16'h0002);
    add_flood(15, 16'h0000, 8'h00, 16'hFFFE);
    // hold off until the directed copies are all back
    pause_q.push_back(beats_q.size());
    base = beats_q.size();
    first = 1'b1;
    mid_paused = 1'b0;
    while (beats_q.size() < base + RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // populate a domain, set its count, then flood it
          d = first ? 14 : $urandom_range(0, NUM_DOMAINS - 1);
          n = (first || $urandom_range(0, 5) == 0) ? MAX_MEMBERS : $urandom_range(1, 6);
          for (int s = 0; s < n; s++)
            add_write(d, s, pick_port(), pick_group(), 1'($urandom_range(0, 1)));
          if (first) add_count(d, 63);
          else add_legal_count(d);
          first = 1'b0;
          repeat ($urandom_range(1, 6)) add_flood(d, pick_port(), pick_group(), 16'($urandom));
        end
        6: add_unused();
        7: add_write($urandom_range(0, NUM_DOMAINS - 1), $urandom_range(0, MAX_MEMBERS - 1),
                     pick_port(), pick_group(), 1'($urandom_range(0, 1)));
        8: add_legal_count($urandom_range(0, NUM_DOMAINS - 1));
        default: add_flood($urandom_range(0, NUM_DOMAINS - 1), pick_port(), pick_group(),
                           16'($urandom));
      endcase
      if (!mid_paused && beats_q.size() >= base + RANDOM_BEATS / 2) begin
        pause_q.push_back(beats_q.size());
        mid_paused = 1'b1;
      end
    end
    total_beats = beats_q.size();
  endtask

  // driver: present the next beat once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        replicate(in_i);
        beats_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pause_q.size() != 0 && beats_sent == pause_q[0] &&
                     copies_q.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (beats_q.size() != 0) begin
          if (pause_q.size() != 0 && beats_sent == pause_q[0]) void'(pause_q.pop_front());
          in_i       <= beats_q.pop_front();
          in_valid_i <= 1'b1;
          beats_sent++;
          if (idle_on() && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // monitor: check each copy beat and stall the output in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (copies_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_o);
        end else begin
          want = copies_q.pop_front();
          check_field("out_packet", want.out_packet, out_o.out_packet);
          check_field("tx_port", want.tx_port, out_o.tx_port);
          check_field("to_bvi", 16'(want.to_bvi), 16'(out_o.to_bvi));
          check_field("dropped", 16'(want.dropped), 16'(out_o.dropped));
          check_field("last", 16'(want.last), 16'(out_o.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int quiet_cycles = 0;
  int seen_in = 0;
  int seen_out = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beats_in != seen_in || beats_out != seen_out) quiet_cycles = 0;
      else quiet_cycles++;
      seen_in  = beats_in;
      seen_out = beats_out;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d copies still outstanding", copies_q.size());
        $display("FAIL l2_flood_replication_filter");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (beats_in < total_beats) @(posedge clk_i);
    while (copies_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d input beats: %0d floods, %0d of them dropped", beats_in, floods,
             drops);
    $display("%0d copy beats checked, %0d mismatches", beats_out, errors);
    if (errors == 0) begin
      $display("PASS l2_flood_replication_filter");
    end else begin
      $display("FAIL l2_flood_replication_filter");
    end
    $finish;
  end

endmodule
